[rtl/core/assert_macros.svh]
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property with asynchronous active-low reset disable.
`define MMCE_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed");

// Same, with a caller-supplied message.
`define MMCE_ASSERT_MSG(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);

`endif

[rtl/core/mmce_pkg.sv]
// Package: types, constants and helpers of the checksum engine.
`timescale 1ns / 1ps
package mmce_pkg;

  typedef enum logic [2:0] {
    ALG_CRC16_MODBUS = 3'd0,
    ALG_CRC16_CCITT  = 3'd1,
    ALG_CRC32        = 3'd2,
    ALG_LRC          = 3'd3,
    ALG_XOR8         = 3'd4,
    ALG_SUM8         = 3'd5
  } alg_e;

  localparam int unsigned ALG_W     = 3;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_DATA_W = 3;

  localparam logic [CFG_IDX_W-1:0] REG_ALGORITHM  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BYTE_ORDER = 2'd1;

  localparam logic [15:0] CRC16_INIT   = 16'hFFFF;
  localparam logic [15:0] MODBUS_POLY  = 16'hA001;
  localparam logic [15:0] CCITT_POLY   = 16'h1021;
  localparam logic [15:0] CCITT_MSB    = 16'h8000;
  localparam logic [31:0] CRC32_INIT   = 32'hFFFF_FFFF;
  localparam logic [31:0] CRC32_POLY   = 32'hEDB8_8320;
  localparam logic [31:0] CRC32_XOROUT = 32'hFFFF_FFFF;

  // Load for the output byte sequencer.
  typedef struct packed {
    logic [31:0] value;
    logic [1:0]  last_idx;
    logic        msb_first;
  } emit_load_t;

  // Unused codes fall back to CRC16-Modbus.
  function automatic alg_e alg_code(input logic [ALG_W-1:0] raw);
    alg_e a;
    case (raw)
      ALG_CRC16_MODBUS: a = ALG_CRC16_MODBUS;
      ALG_CRC16_CCITT:  a = ALG_CRC16_CCITT;
      ALG_CRC32:        a = ALG_CRC32;
      ALG_LRC:          a = ALG_LRC;
      ALG_XOR8:         a = ALG_XOR8;
      ALG_SUM8:         a = ALG_SUM8;
      default:          a = ALG_CRC16_MODBUS;
    endcase
    return a;
  endfunction

  function automatic logic [31:0] init_value(input alg_e a);
    logic [31:0] v;
    case (a)
      ALG_CRC16_MODBUS, ALG_CRC16_CCITT: v = {16'h0000, CRC16_INIT};
      ALG_CRC32:                         v = CRC32_INIT;
      default:                           v = 32'h0000_0000;
    endcase
    return v;
  endfunction

  // Index of the final checksum byte (byte count minus one).
  function automatic logic [1:0] last_index(input alg_e a);
    logic [1:0] n;
    case (a)
      ALG_CRC16_MODBUS, ALG_CRC16_CCITT: n = 2'd1;
      ALG_CRC32:                         n = 2'd3;
      default:                           n = 2'd0;
    endcase
    return n;
  endfunction

endpackage

[rtl/core/mmce_if.sv]
// Valid/ready channel interfaces for message bytes and checksum bytes.
`timescale 1ns / 1ps
interface mmce_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       end_of_message;

  modport source (output valid, output data_byte, output end_of_message, input ready);
  modport sink   (input valid, input data_byte, input end_of_message, output ready);
endinterface

interface mmce_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  checksum_byte;
  logic        last_byte;
  logic [31:0] checksum_value;

  modport source (output valid, output checksum_byte, output last_byte,
                  output checksum_value, input ready);
  modport sink   (input valid, input checksum_byte, input last_byte,
                  input checksum_value, output ready);
endinterface

[rtl/core/mmce_fold.sv]
// Byte fold: one unrolled update of the running checksum plus finishing.
`timescale 1ns / 1ps
module mmce_fold import mmce_pkg::*; (
  input  alg_e        alg_i,
  input  logic        open_i,
  input  logic [31:0] csum_i,
  input  logic [7:0]  byte_i,
  output logic [31:0] next_o,
  output logic [31:0] final_o
);

  logic [31:0] start;
  logic [15:0] r16_modbus;
  logic [15:0] r16_ccitt;
  logic [31:0] r32;

  // Fresh message starts from the algorithm's initial value
  assign start = open_i ? csum_i : init_value(alg_i);

  // Eight bit steps of each CRC, unrolled
  always_comb begin
    r16_modbus = start[15:0] ^ {8'h00, byte_i};
    r16_ccitt  = start[15:0] ^ {byte_i, 8'h00};
    r32        = start ^ {24'h000000, byte_i};
    for (int i = 0; i < 8; i++) begin
      r16_modbus = r16_modbus[0] ? ((r16_modbus >> 1) ^ MODBUS_POLY) : (r16_modbus >> 1);
      r16_ccitt  = ((r16_ccitt & CCITT_MSB) != 16'h0000) ?
                   ((r16_ccitt << 1) ^ CCITT_POLY) : (r16_ccitt << 1);
      r32        = r32[0] ? ((r32 >> 1) ^ CRC32_POLY) : (r32 >> 1);
    end
  end

  // Select the updated register
  always_comb begin
    case (alg_i)
      ALG_CRC16_MODBUS: next_o = {16'h0000, r16_modbus};
      ALG_CRC16_CCITT:  next_o = {16'h0000, r16_ccitt};
      ALG_CRC32:        next_o = r32;
      ALG_XOR8:         next_o = {24'h000000, start[7:0] ^ byte_i};
      default:          next_o = {24'h000000, 8'(start[7:0] + byte_i)};
    endcase
  end

  // Finished value: CRC32 inverted, LRC negated
  always_comb begin
    case (alg_i)
      ALG_CRC32: final_o = next_o ^ CRC32_XOROUT;
      ALG_LRC:   final_o = {24'h000000, 8'(8'h00 - next_o[7:0])};
      default:   final_o = next_o;
    endcase
  end

endmodule

[rtl/core/mmce_emit.sv]
// Output sequencer: registers a finished checksum and sends it byte by byte.
`timescale 1ns / 1ps
module mmce_emit import mmce_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        load_en_i,
  input  emit_load_t  load_i,
  output logic        load_ready_o,
  output logic        valid_o,
  input  logic        ready_i,
  output logic [7:0]  checksum_byte_o,
  output logic        last_byte_o,
  output logic [31:0] checksum_value_o
);

  logic        valid_q;
  logic [1:0]  k_q;
  logic [31:0] value_q;
  logic [1:0]  last_q;
  logic        msb_q;
  logic [1:0]  idx;
  logic        at_last;

  assign at_last      = (k_q == last_q);
  assign load_ready_o = !valid_q || (ready_i && at_last);

  // Control: run valid and byte counter
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      k_q     <= 2'd0;
    end else if (load_en_i) begin
      valid_q <= 1'b1;
      k_q     <= 2'd0;
    end else if (valid_q && ready_i) begin
      if (at_last) begin
        valid_q <= 1'b0;
      end else begin
        k_q <= k_q + 2'd1;
      end
    end
  end

  // Payload of the run
  always_ff @(posedge clk_i) begin
    if (load_en_i) begin
      value_q <= load_i.value;
      last_q  <= load_i.last_idx;
      msb_q   <= load_i.msb_first;
    end
  end

  // Byte select in configured order
  assign idx              = msb_q ? 2'(last_q - k_q) : k_q;
  assign checksum_byte_o  = 8'(value_q >> {idx, 3'b000});
  assign last_byte_o      = at_last;
  assign checksum_value_o = value_q;
  assign valid_o          = valid_q;

endmodule

[rtl/core/multi_mode_checksum_engine_unit.sv]
// Top level of the multi-mode checksum engine.
`timescale 1ns / 1ps
// Folds one message byte per request into a running CRC16-Modbus,
// CRC16-CCITT-FALSE, CRC32, LRC, XOR8 or SUM8 checksum, chosen by the
// algorithm register (codes 6 and 7 run CRC16-Modbus). A byte flagged
// end_of_message closes the message: its checksum leaves as 1, 2 or 4
// result requests (LSB or MSB first per byte_order), the last one flagged
// last_byte, each carrying the whole value. Throughput is one byte per
// cycle while a message streams in. After the end byte, input stalls
// until the final checksum byte is taken; a new byte is accepted in that
// same cycle. The pace is set by the single output register of the byte
// sequencer. Configuration writes belong to idle periods.
module multi_mode_checksum_engine_unit import mmce_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  mmce_in_if.sink               in_if,
  mmce_out_if.source            out_if
);

  logic [ALG_W-1:0] alg_q;
  logic             order_q;
  logic [31:0]      csum_q;
  logic             open_q;
  alg_e             alg;
  logic [31:0]      csum_next;
  logic [31:0]      csum_final;
  logic             accept;
  logic             load_en;
  logic             load_ready;
  emit_load_t       load;

  assign alg     = alg_code(alg_q);
  assign accept  = in_if.valid && load_ready;
  assign load_en = accept && in_if.end_of_message;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      alg_q   <= ALG_CRC16_MODBUS;
      order_q <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_ALGORITHM:  alg_q   <= cfg_data_i;
        REG_BYTE_ORDER: order_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // Running checksum and message state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      csum_q <= {16'h0000, CRC16_INIT};
      open_q <= 1'b0;
    end else if (accept) begin
      csum_q <= csum_next;
      open_q <= !in_if.end_of_message;
    end
  end

  mmce_fold u_fold (
    .alg_i   (alg),
    .open_i  (open_q),
    .csum_i  (csum_q),
    .byte_i  (in_if.data_byte),
    .next_o  (csum_next),
    .final_o (csum_final)
  );

  // Finished checksum handed to the sequencer
  always_comb begin
    load.value     = csum_final;
    load.last_idx  = last_index(alg);
    load.msb_first = order_q;
  end

  mmce_emit u_emit (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .load_en_i        (load_en),
    .load_i           (load),
    .load_ready_o     (load_ready),
    .valid_o          (out_if.valid),
    .ready_i          (out_if.ready),
    .checksum_byte_o  (out_if.checksum_byte),
    .last_byte_o      (out_if.last_byte),
    .checksum_value_o (out_if.checksum_value)
  );

  assign in_if.ready = load_ready;

endmodule

[rtl/core/mmce_checker.sv]
// Port-level checker of the checksum engine, bound to the top level.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module mmce_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_i,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic        out_last_i,
  input logic [31:0] out_value_i
);

  // A stalled checksum byte stays offered
  `MMCE_ASSERT(a_out_hold, clk_i, rst_ni, out_valid_i && !out_ready_i |=> out_valid_i)

  // Input is blocked while a checksum run is still pending
  `MMCE_ASSERT_MSG(a_in_blocked, clk_i, rst_ni,
    out_valid_i && !(out_ready_i && out_last_i) |-> !in_ready_i,
    "input accepted during checksum run")

  // A run continues after a non-final byte with the same full value
  `MMCE_ASSERT_MSG(a_run_value, clk_i, rst_ni,
    out_valid_i && out_ready_i && !out_last_i |=> out_valid_i && $stable(out_value_i),
    "checksum value changed within a run")

  // Idle output side always takes a new byte
  `MMCE_ASSERT(a_idle_ready, clk_i, rst_ni, !out_valid_i |-> in_ready_i)

  // A run starts from idle only after an input request was taken
  `MMCE_ASSERT_MSG(a_run_cause, clk_i, rst_ni,
    !out_valid_i ##1 out_valid_i |-> $past(in_valid_i && in_ready_i),
    "checksum run without an accepted request")

endmodule

bind multi_mode_checksum_engine_unit mmce_checker u_mmce_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_if.valid),
  .in_ready_i  (in_if.ready),
  .out_valid_i (out_if.valid),
  .out_ready_i (out_if.ready),
  .out_last_i  (out_if.last_byte),
  .out_value_i (out_if.checksum_value)
);

[tb/tb_top.sv]
// Self-checking testbench for the multi-mode checksum engine.
`timescale 1ns / 1ps
module tb_top;
  import mmce_pkg::*;

  // Register slots with no register
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_2 = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_3 = 2'd3;

  localparam int SETTLE_CYCLES = 16;
  localparam int HOLD_CYCLES   = 120;
  localparam int PHASES        = 18;
  localparam int PHASE_BYTES   = 24;

  typedef struct {
    logic [7:0] data;
    logic       eom;
  } msg_byte_t;

  typedef struct {
    logic [7:0]  cbyte;
    logic        last;
    logic [31:0] value;
  } csum_byte_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  // Drive side of both channels and the config port
  logic                  src_valid = 1'b0;
  logic [7:0]            src_data  = 8'h00;
  logic                  src_eom   = 1'b0;
  logic                  sink_ready = 1'b0;
  logic                  cfg_we   = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx  = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  // Flow control knobs
  int src_idle_pct  = 0;
  int sink_idle_pct = 0;
  bit src_pause     = 1'b0;
  int hold_req      = 0;
  int hold_ack      = 0;
  int hold_left     = 0;

  // Pending message bytes and the checksum bytes we expect back
  msg_byte_t  byte_q[$];
  csum_byte_t csum_q[$];
  int         err_count = 0;

  // Shadow of the engine: configuration and running checksum
  logic [ALG_W-1:0] cur_alg = ALG_CRC16_MODBUS;
  logic             cur_msb_first = 1'b0;
  logic [31:0]      run_sum = {16'h0000, CRC16_INIT};
  logic             msg_open = 1'b0;

  mmce_in_if  in_if ();
  mmce_out_if out_if ();

  assign in_if.valid          = src_valid;
  assign in_if.data_byte      = src_data;
  assign in_if.end_of_message = src_eom;
  assign out_if.ready         = sink_ready;

  multi_mode_checksum_engine_unit dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data),
    .in_if      (in_if),
    .out_if     (out_if)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Unused codes run CRC16-Modbus
  function automatic alg_e eff_alg(input logic [ALG_W-1:0] raw);
    return (raw > ALG_SUM8) ? ALG_CRC16_MODBUS : alg_e'(raw);
  endfunction

  function automatic logic [31:0] start_value(input alg_e a);
    case (a)
      ALG_CRC16_MODBUS, ALG_CRC16_CCITT: return {16'h0000, CRC16_INIT};
      ALG_CRC32:                         return CRC32_INIT;
      default:                           return 32'h0000_0000;
    endcase
  endfunction

  // Fold one accepted byte into the shadow checksum; queue the checksum on end of message
  function automatic void fold_message_byte(input msg_byte_t it);
    alg_e        a;
    logic [15:0] r16;
    logic [31:0] v;
    int          n;
    int          idx;
    csum_byte_t  e;
    a = eff_alg(cur_alg);
    if (!msg_open) run_sum = start_value(a);
    case (a)
      ALG_CRC16_MODBUS: begin
        r16 = run_sum[15:0] ^ {8'h00, it.data};
        for (int i = 0; i < 8; i++)
          r16 = r16[0] ? ((r16 >> 1) ^ MODBUS_POLY) : (r16 >> 1);
        run_sum = {16'h0000, r16};
      end
      ALG_CRC16_CCITT: begin
        r16 = run_sum[15:0] ^ {it.data, 8'h00};
        for (int i = 0; i < 8; i++)
          r16 = (r16 & CCITT_MSB) != 16'h0000 ? ((r16 << 1) ^ CCITT_POLY) : (r16 << 1);
        run_sum = {16'h0000, r16};
      end
      ALG_CRC32: begin
        run_sum = run_sum ^ {24'h000000, it.data};
        for (int i = 0; i < 8; i++)
          run_sum = run_sum[0] ? ((run_sum >> 1) ^ CRC32_POLY) : (run_sum >> 1);
      end
      ALG_XOR8: run_sum = {24'h000000, run_sum[7:0] ^ it.data};
      // LRC keeps the plain sum, negated only on output
      default:  run_sum = {24'h000000, run_sum[7:0] + it.data};
    endcase
    if (!it.eom) begin
      msg_open = 1'b1;
      return;
    end
    case (a)
      ALG_CRC32: v = run_sum ^ CRC32_XOROUT;
      ALG_LRC:   v = {24'h000000, 8'h00 - run_sum[7:0]};
      default:   v = run_sum;
    endcase
    case (a)
      ALG_CRC16_MODBUS, ALG_CRC16_CCITT: n = 2;
      ALG_CRC32:                         n = 4;
      default:                           n = 1;
    endcase
    for (int k = 0; k < n; k++) begin
      idx     = cur_msb_first ? (n - 1 - k) : k;
      e.cbyte = v[8*idx +: 8];
      e.last  = (k == n - 1);
      e.value = v;
      csum_q.push_back(e);
    end
    run_sum  = start_value(a);
    msg_open = 1'b0;
  endfunction

  function automatic void push_byte(input logic [7:0] d, input logic e);
    msg_byte_t it;
    it.data = d;
    it.eom  = e;
    byte_q.push_back(it);
  endfunction

  // One message of random bytes, biased toward the extremes; open-ended if close is 0
  function automatic void push_message(input int len, input bit close);
    logic [7:0] d;
    for (int i = 0; i < len; i++) begin
      case ($urandom_range(7))
        0:       d = 8'h00;
        1:       d = 8'hFF;
        default: d = 8'($urandom);
      endcase
      push_byte(d, close && (i == len - 1));
    end
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("%0t ns: mismatch on %s: got %0h, expected %0h", $time, what, got, want);
    err_count++;
  endtask

  // Wait until every byte is taken and every checksum byte is back
  task automatic settle();
    while (byte_q.size() != 0 || src_valid || csum_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    @(posedge clk_i);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= data;
    @(posedge clk_i);
    cfg_we <= 1'b0;
    // Mirror the write; an idle algorithm change re-arms the register
    if (idx == REG_ALGORITHM) begin
      cur_alg = data;
      if (!msg_open) run_sum = start_value(eff_alg(cur_alg));
    end else if (idx == REG_BYTE_ORDER) begin
      cur_msb_first = data[0];
    end
  endtask

  // Byte driver: holds an offered request until taken, then picks the next one
  always @(posedge clk_i) begin : drive_bytes
    logic keep_offer;
    keep_offer = src_valid && !in_if.ready;
    if (rst_ni) begin
      if (src_valid && in_if.ready) begin
        fold_message_byte(byte_q[0]);
        void'(byte_q.pop_front());
      end
      if (!keep_offer) begin
        if (byte_q.size() != 0 && !src_pause && $urandom_range(99) >= src_idle_pct) begin
          src_valid <= 1'b1;
          src_data  <= byte_q[0].data;
          src_eom   <= byte_q[0].eom;
        end else begin
          src_valid <= 1'b0;
        end
      end
    end
  end

  // Long receiver hold-off, counted here
  always @(posedge clk_i) begin : count_hold
    if (hold_req != hold_ack) begin
      hold_left <= HOLD_CYCLES;
      hold_ack  <= hold_req;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  always @(posedge clk_i) begin : drive_ready
    sink_ready <= rst_ni && (hold_left == 0) && ($urandom_range(99) >= sink_idle_pct);
  end

  // Checksum monitor: compare each taken byte with the oldest expectation
  always @(posedge clk_i) begin : check_checksum
    csum_byte_t want;
    if (rst_ni && out_if.valid && out_if.ready) begin
      if (csum_q.size() == 0) begin
        report_mismatch("checksum byte with nothing pending", {24'h0, out_if.checksum_byte}, 0);
      end else begin
        want = csum_q.pop_front();
        if (out_if.checksum_byte !== want.cbyte)
          report_mismatch("checksum_byte", {24'h0, out_if.checksum_byte}, {24'h0, want.cbyte});
        if (out_if.last_byte !== want.last)
          report_mismatch("last_byte", {31'h0, out_if.last_byte}, {31'h0, want.last});
        if (out_if.checksum_value !== want.value)
          report_mismatch("checksum_value", out_if.checksum_value, want.value);
      end
    end
  end

  initial begin : stimulus
    int pushed;
    int len;
    src_idle_pct  = 33;
    sink_idle_pct = 79;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Single-byte messages under reset settings
    push_byte(8'h00, 1'b1);
    push_byte(8'hFF, 1'b1);
    settle();

    // Writes to slots with no register must change nothing
    write_reg(REG_SPARE_2, 3'b111);
    write_reg(REG_SPARE_3, 3'b101);

    // Every algorithm code, both byte orders
    for (int c = 0; c < 8; c++) begin
      write_reg(REG_ALGORITHM, 3'(c));
      write_reg(REG_BYTE_ORDER, 3'(c));
      push_byte(8'h00, 1'b0);
      push_byte(8'hFF, 1'b1);
      settle();
    end

    // Algorithm and byte order changed in the middle of a message
    write_reg(REG_ALGORITHM, ALG_CRC32);
    write_reg(REG_BYTE_ORDER, 3'b000);
    push_byte(8'h31, 1'b0);
    settle();
    write_reg(REG_ALGORITHM, ALG_CRC16_CCITT);
    write_reg(REG_BYTE_ORDER, 3'b001);
    push_byte(8'h32, 1'b0);
    settle();
    write_reg(REG_ALGORITHM, ALG_XOR8);
    push_byte(8'h33, 1'b1);
    settle();

    // Random phases: each code twice or more, three idle profiles
    for (int ph = 0; ph < PHASES; ph++) begin
      if (ph == PHASES / 3) begin
        src_idle_pct  = 79;
        sink_idle_pct = 33;
      end else if (ph == 2 * PHASES / 3) begin
        src_idle_pct  = 0;
        sink_idle_pct = 0;
      end
      write_reg(REG_ALGORITHM, 3'(ph));
      write_reg(REG_BYTE_ORDER, 3'($urandom_range(7)));
      if ($urandom_range(4) == 0)
        write_reg($urandom_range(1) ? REG_SPARE_2 : REG_SPARE_3, 3'($urandom));

      pushed = 0;
      while (pushed < PHASE_BYTES) begin
        len = ($urandom_range(9) == 0) ? $urandom_range(7, 24) : $urandom_range(1, 6);
        push_message(len, 1'b1);
        pushed += len;
      end

      // Back-pressure: receiver stalls while the sender keeps offering
      if (ph == 2 * PHASES / 3) hold_req++;

      // Sender stops halfway until all checksums are back
      if (ph == 3) begin
        while (byte_q.size() > pushed / 2) @(posedge clk_i);
        src_pause = 1'b1;
        while (csum_q.size() != 0 || src_valid) @(posedge clk_i);
        repeat (5) @(posedge clk_i);
        src_pause = 1'b0;
      end

      // Sometimes leave a message open across the next config writes
      if (ph != PHASES - 1 && $urandom_range(3) == 0)
        push_message($urandom_range(1, 3), 1'b0);
      settle();
    end

    if (err_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  initial begin : watchdog
    #10_000_000;
    $display("TEST FAILED");
    $finish;
  end

endmodule
